### rtl/palette_range_cycler_defines.svh
// Assertion macros shared by the palette range cycler RTL.
// Uses the clk and arst_n signals of the module that expands them.
`ifndef PALETTE_RANGE_CYCLER_DEFINES_SVH
`define PALETTE_RANGE_CYCLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pcr_pkg.sv
// Shared types and constants of the palette range cycler.
// No dependencies.
package pcr_pkg;

	localparam logic [2:0] CMD_LOAD  = 3'd0;
	localparam logic [2:0] CMD_CYCLE = 3'd1;
	localparam logic [2:0] CMD_SHR   = 3'd2;
	localparam logic [2:0] CMD_SHL   = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	localparam int QUEUE_DEPTH = 2;
	localparam int COUNT_W     = 32;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_IGNORE,
		OP_LOAD,
		OP_CYCLE,
		OP_SHR,
		OP_SHL,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [7:0]          index;
		logic [31:0]         colour;
		logic [7:0]          lo;
		logic [7:0]          hi;
		logic [COUNT_W-1:0]  count;
		logic [15:0]         tween;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_SWEEP,
		ST_SHIFT,
		ST_SHEND,
		ST_READ,
		ST_RESULT
	} state_t;

endpackage

### rtl/palette_range_cycler.sv
// Palette range cycler top level: front end, operation queue, back end and mode register.
// Depends on pcr_pkg, pcr_front, pcr_fifo and pcr_back.
// Input items (cmd and operands) arrive on a valid/ready channel; every item yields exactly
// one result item (read_colour, ignored) on a valid/ready output channel, in order.
// The cfg channel writes blend_mode and is always ready; write it only while the block is idle.
// The front end classifies each item and places it in a two-entry queue, so up to two items
// are taken while the back end is busy or the receiver stalls.
// A cycle command runs a 32-step remainder and then one source palette read per entry plus
// one more, with one working write per entry.
// The back end handles one item at a time; with the next item already queued it starts it
// in the cycle after each result is formed.
// A stalled receiver holds one finished result in the output register; the back end then
// waits and the queue fills before in_ready drops.
// Reset clears the control logic and sets blend_mode to 1; palette contents are not cleared.
module palette_range_cycler #(
	parameter int PALETTE_ENTRIES = 256,
	parameter int TWEEN_BITS      = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    cmd,
	input  logic [7:0]                    entry_index,
	input  logic [31:0]                   entry_colour,
	input  logic [7:0]                    range_low,
	input  logic [7:0]                    range_high,
	input  logic signed [31:0]            cycle_count,
	input  logic [15:0]                   tween_frac,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [31:0]                   read_colour,
	output logic                          ignored
);

	logic            blend_mode_q;
	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_valid;
	pcr_pkg::item_t  q_item;
	pcr_pkg::item_t  q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q <= 1'b1;
		end else if (cfg_valid) begin
			blend_mode_q <= cfg_data;
		end
	end

	pcr_front #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.entry_index  (entry_index),
		.entry_colour (entry_colour),
		.range_low    (range_low),
		.range_high   (range_high),
		.cycle_count  (cycle_count),
		.tween_frac   (tween_frac),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_item)
	);

	pcr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.item_in (q_item),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.head    (q_head)
	);

	pcr_back #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES),
		.TWEEN_BITS      (TWEEN_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.blend_mode  (blend_mode_q),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_colour (read_colour),
		.ignored     (ignored)
	);

endmodule

### rtl/pcr_front.sv
// Front end: accepts input items and classifies them into queue operations.
// Depends on pcr_pkg.
module pcr_front #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    cmd,
	input  logic [7:0]                    entry_index,
	input  logic [31:0]                   entry_colour,
	input  logic [7:0]                    range_low,
	input  logic [7:0]                    range_high,
	input  logic [pcr_pkg::COUNT_W-1:0]   cycle_count,
	input  logic [15:0]                   tween_frac,
	input  logic                          q_full,
	output logic                          q_push,
	output pcr_pkg::item_t                q_item
);

	localparam logic [8:0] LIMIT = 9'(PALETTE_ENTRIES);

	logic idx_ok;
	logic rng_ok;
	pcr_pkg::op_t op;

	assign idx_ok = {1'b0, entry_index} < LIMIT;
	assign rng_ok = (range_low < range_high) && ({1'b0, range_high} < LIMIT);

	always_comb begin
		op = pcr_pkg::OP_NONE;
		unique case (cmd)
			pcr_pkg::CMD_LOAD:  op = idx_ok ? pcr_pkg::OP_LOAD : pcr_pkg::OP_NONE;
			pcr_pkg::CMD_CYCLE: op = rng_ok ? pcr_pkg::OP_CYCLE : pcr_pkg::OP_IGNORE;
			pcr_pkg::CMD_SHR:   op = rng_ok ? pcr_pkg::OP_SHR : pcr_pkg::OP_IGNORE;
			pcr_pkg::CMD_SHL:   op = rng_ok ? pcr_pkg::OP_SHL : pcr_pkg::OP_IGNORE;
			pcr_pkg::CMD_READ:  op = idx_ok ? pcr_pkg::OP_READ : pcr_pkg::OP_NONE;
			default:            op = pcr_pkg::OP_NONE;
		endcase
	end

	always_comb begin
		q_item.op     = op;
		q_item.index  = entry_index;
		q_item.colour = entry_colour;
		q_item.lo     = range_low;
		q_item.hi     = range_high;
		q_item.count  = cycle_count;
		q_item.tween  = tween_frac;
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

endmodule

### rtl/pcr_fifo.sv
// Short queue of classified operations between the front and back ends.
// Depends on pcr_pkg.
module pcr_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pcr_pkg::item_t  item_in,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output pcr_pkg::item_t  head
);

	localparam int DEPTH = pcr_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pcr_pkg::item_t     entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full  = cnt_q == CNT_W'(DEPTH);
	assign valid = cnt_q != '0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

### rtl/pcr_mod.sv
// Bit-serial Euclidean remainder of the signed cycle count by the range length.
// Depends on pcr_pkg.
module pcr_mod #(
	parameter int IDX_W = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pcr_pkg::COUNT_W-1:0]   count,
	input  logic [IDX_W:0]                len,
	output logic                          done,
	output logic [IDX_W-1:0]              frame
);

	localparam int CW     = pcr_pkg::COUNT_W;
	localparam int STEP_W = $clog2(CW);

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [CW-1:0]     mag_q;
	logic [IDX_W-1:0]  rem_q;
	logic [IDX_W:0]    len_q;
	logic [STEP_W-1:0] step_q;
	logic [IDX_W:0]    trial;

	assign trial = {rem_q, mag_q[CW-1]};
	assign done  = done_q;
	assign frame = (neg_q && rem_q != '0) ? IDX_W'(len_q - {1'b0, rem_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && step_q == STEP_W'(CW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= count[CW-1];
			mag_q  <= count[CW-1] ? (~count + CW'(1)) : count;
			rem_q  <= '0;
			len_q  <= len;
			step_q <= '0;
		end else if (busy_q) begin
			rem_q  <= (trial >= len_q) ? IDX_W'(trial - len_q) : IDX_W'(trial);
			mag_q  <= {mag_q[CW-2:0], 1'b0};
			step_q <= step_q + STEP_W'(1);
		end
	end

endmodule

### rtl/pcr_back.sv
// Back end: sequencer, source and working palette memories and byte blender.
// Depends on pcr_pkg, pcr_mod and palette_range_cycler_defines.svh.
`include "palette_range_cycler_defines.svh"

module pcr_back #(
	parameter int PALETTE_ENTRIES = 256,
	parameter int TWEEN_BITS      = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            blend_mode,
	input  logic            q_valid,
	input  pcr_pkg::item_t  q_head,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     read_colour,
	output logic            ignored
);

	localparam int IDX_W  = $clog2(PALETTE_ENTRIES);
	localparam int LEN_W  = IDX_W + 1;
	localparam int PROD_W = TWEEN_BITS + 10;

	pcr_pkg::state_t state_q;
	pcr_pkg::state_t state_d;
	pcr_pkg::item_t  cur_q;

	logic [31:0] src_mem [PALETTE_ENTRIES];
	logic [31:0] wrk_mem [PALETTE_ENTRIES];

	logic             src_we;
	logic             src_re;
	logic [IDX_W-1:0] src_ra;
	logic [31:0]      src_rd_q;
	logic             wrk_we;
	logic [IDX_W-1:0] wrk_wa;
	logic [31:0]      wrk_wd;
	logic             wrk_re;
	logic [IDX_W-1:0] wrk_ra;
	logic [31:0]      wrk_rd_q;

	logic [IDX_W-1:0] head_idx;
	logic [IDX_W-1:0] head_lo;
	logic [IDX_W-1:0] head_hi;
	logic [IDX_W-1:0] cur_lo;
	logic [LEN_W-1:0] head_len;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] ic_q;
	logic [LEN_W-1:0] n_last_q;

	logic             issue;
	logic             issue_act_q;
	logic             res_load;
	logic [IDX_W-1:0] rp_q;
	logic [IDX_W-1:0] ra_q;
	logic [IDX_W-1:0] wa_q;
	logic [IDX_W-1:0] a_s1;
	logic [IDX_W-1:0] prev_a_q;
	logic [IDX_W-1:0] mix_a_s2;
	logic             rd_v_s1;
	logic             first_s1;
	logic             mix_v_s2;
	logic [31:0]      prev_q;
	logic [31:0]      keep_q;
	logic [31:0]      mix_s2;
	wire  [31:0]      mix_d;
	logic [31:0]      res_colour_q;
	logic             res_ign_q;
	logic             out_valid_q;
	logic [31:0]      out_colour_q;
	logic             out_ign_q;

	logic             mod_start;
	logic             mod_done;
	logic [IDX_W-1:0] mod_frame;

	logic [TWEEN_BITS-1:0] t_raw;
	logic [TWEEN_BITS-1:0] t_eff;

	assign head_idx = q_head.index[IDX_W-1:0];
	assign head_lo  = q_head.lo[IDX_W-1:0];
	assign head_hi  = q_head.hi[IDX_W-1:0];
	assign cur_lo   = cur_q.lo[IDX_W-1:0];
	assign head_len = {1'b0, head_hi} - {1'b0, head_lo} + LEN_W'(1);
	assign res_load = (state_q == pcr_pkg::ST_RESULT) && (!out_valid_q || out_ready);

	pcr_mod #(
		.IDX_W (IDX_W)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.count  (q_head.count),
		.len    (head_len),
		.done   (mod_done),
		.frame  (mod_frame)
	);

	if (TWEEN_BITS <= $bits(cur_q.tween)) begin : g_tw_narrow
		assign t_raw = cur_q.tween[TWEEN_BITS-1:0];
	end else begin : g_tw_wide
		assign t_raw = TWEEN_BITS'(cur_q.tween);
	end

	assign t_eff = blend_mode ? t_raw : '0;

	// Each byte is old + floor((new - old) * t / 2^T), which equals the weighted sum form.
	for (genvar b = 0; b < 4; b++) begin : g_lane
		logic [7:0]               x;
		logic [7:0]               y;
		logic signed [8:0]        diff;
		logic signed [PROD_W-1:0] prod;

		assign x    = prev_q[8*b +: 8];
		assign y    = src_rd_q[8*b +: 8];
		assign diff = $signed({1'b0, y}) - $signed({1'b0, x});
		assign prod = diff * $signed({1'b0, t_eff});
		assign mix_d[8*b +: 8] = x + prod[TWEEN_BITS +: 8];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcr_pkg::ST_IDLE: begin
				if (q_valid) begin
					unique case (q_head.op) inside
						pcr_pkg::OP_CYCLE:                  state_d = pcr_pkg::ST_MOD;
						pcr_pkg::OP_READ:                   state_d = pcr_pkg::ST_READ;
						pcr_pkg::OP_SHR, pcr_pkg::OP_SHL:   state_d = pcr_pkg::ST_SHIFT;
						default:                            state_d = pcr_pkg::ST_RESULT;
					endcase
				end
			end
			pcr_pkg::ST_MOD: begin
				if (mod_done) begin
					state_d = pcr_pkg::ST_SWEEP;
				end
			end
			pcr_pkg::ST_SWEEP: begin
				if (!issue_act_q && !rd_v_s1 && !mix_v_s2) begin
					state_d = pcr_pkg::ST_RESULT;
				end
			end
			pcr_pkg::ST_SHIFT: begin
				if (!issue_act_q && !rd_v_s1) begin
					state_d = pcr_pkg::ST_SHEND;
				end
			end
			pcr_pkg::ST_SHEND:  state_d = pcr_pkg::ST_RESULT;
			pcr_pkg::ST_READ:   state_d = pcr_pkg::ST_RESULT;
			pcr_pkg::ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					state_d = pcr_pkg::ST_IDLE;
				end
			end
			default: state_d = pcr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		mod_start = 1'b0;
		issue     = 1'b0;
		src_we    = 1'b0;
		src_re    = 1'b0;
		src_ra    = cur_lo + rp_q;
		wrk_we    = 1'b0;
		wrk_wa    = head_idx;
		wrk_wd    = q_head.colour;
		wrk_re    = 1'b0;
		wrk_ra    = head_idx;
		unique case (state_q)
			pcr_pkg::ST_IDLE: begin
				q_pop = q_valid;
				if (q_valid) begin
					mod_start = q_head.op == pcr_pkg::OP_CYCLE;
					src_we    = q_head.op == pcr_pkg::OP_LOAD;
					wrk_we    = q_head.op == pcr_pkg::OP_LOAD;
					wrk_re    = q_head.op == pcr_pkg::OP_READ;
				end
			end
			pcr_pkg::ST_SWEEP: begin
				issue  = issue_act_q;
				src_re = issue_act_q;
				wrk_we = mix_v_s2;
				wrk_wa = mix_a_s2;
				wrk_wd = mix_s2;
			end
			pcr_pkg::ST_SHIFT: begin
				issue  = issue_act_q;
				wrk_re = issue_act_q;
				wrk_ra = ra_q;
				wrk_we = rd_v_s1 && !first_s1;
				wrk_wa = prev_a_q;
				wrk_wd = wrk_rd_q;
			end
			pcr_pkg::ST_SHEND: begin
				wrk_we = 1'b1;
				wrk_wa = prev_a_q;
				wrk_wd = keep_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (src_we) begin
			src_mem[head_idx] <= q_head.colour;
		end
		if (src_re) begin
			src_rd_q <= src_mem[src_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (wrk_we) begin
			wrk_mem[wrk_wa] <= wrk_wd;
		end
		if (wrk_re) begin
			wrk_rd_q <= wrk_mem[wrk_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcr_pkg::ST_IDLE;
			issue_act_q <= 1'b0;
			rd_v_s1     <= 1'b0;
			mix_v_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_v_s1  <= issue;
			mix_v_s2 <= rd_v_s1 && !first_s1 && (state_q == pcr_pkg::ST_SWEEP);
			if (q_pop && (q_head.op == pcr_pkg::OP_SHR || q_head.op == pcr_pkg::OP_SHL)) begin
				issue_act_q <= 1'b1;
			end else if (state_q == pcr_pkg::ST_MOD && mod_done) begin
				issue_act_q <= 1'b1;
			end else if (issue && ic_q == n_last_q) begin
				issue_act_q <= 1'b0;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q        <= q_head;
			len_q        <= head_len;
			res_colour_q <= '0;
			res_ign_q    <= q_head.op == pcr_pkg::OP_IGNORE;
			ic_q         <= '0;
			n_last_q     <= head_len - LEN_W'(1);
			ra_q         <= (q_head.op == pcr_pkg::OP_SHR) ? head_hi : head_lo;
		end
		if (state_q == pcr_pkg::ST_MOD && mod_done) begin
			ic_q     <= '0;
			n_last_q <= len_q;
			rp_q     <= mod_frame;
			wa_q     <= cur_lo;
		end
		if (issue) begin
			ic_q     <= ic_q + LEN_W'(1);
			rp_q     <= ({1'b0, rp_q} + LEN_W'(1) == len_q) ? '0 : rp_q + IDX_W'(1);
			ra_q     <= (cur_q.op == pcr_pkg::OP_SHR) ? ra_q - IDX_W'(1) : ra_q + IDX_W'(1);
			a_s1     <= ra_q;
			first_s1 <= ic_q == '0;
		end
		if (rd_v_s1 && state_q == pcr_pkg::ST_SWEEP) begin
			prev_q <= src_rd_q;
			if (!first_s1) begin
				mix_s2   <= mix_d;
				mix_a_s2 <= wa_q;
				wa_q     <= wa_q + IDX_W'(1);
			end
		end
		if (rd_v_s1 && state_q == pcr_pkg::ST_SHIFT) begin
			if (first_s1) begin
				keep_q <= wrk_rd_q;
			end
			prev_a_q <= a_s1;
		end
		if (state_q == pcr_pkg::ST_READ) begin
			res_colour_q <= wrk_rd_q;
		end
		if (res_load) begin
			out_colour_q <= res_colour_q;
			out_ign_q    <= res_ign_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_colour = out_colour_q;
	assign ignored     = out_ign_q;

	`PCR_ASSERT_IMP(a_frame_below_len, mod_done, LEN_W'(mod_frame) < len_q, "remainder not below range length")
	`PCR_ASSERT_IMP(a_s1_in_sweep, rd_v_s1, state_q == pcr_pkg::ST_SWEEP || state_q == pcr_pkg::ST_SHIFT, "read pipeline active outside a sweep")
	`PCR_ASSERT_IMP(a_out_from_result, $rose(out_valid_q), $past(state_q) == pcr_pkg::ST_RESULT, "result shown without result step")
	`PCR_ASSERT_NXT(a_result_lands, state_q == pcr_pkg::ST_RESULT && !out_valid_q, out_valid_q, "free output slot not filled")

endmodule
